// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// types and constants of the ascii radix number parser
// ----------------------------------------------------------------------------
`default_nettype none

package arp_pkg;

    // field widths
    localparam int CH_W       = 8;
    localparam int VAL_W      = 63;
    localparam int CNT_W      = 10;
    localparam int DIGIT_W    = 4;
    localparam int PROD_W     = VAL_W + DIGIT_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = VAL_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    // ascii codes
    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_F = 8'h66;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_F = 8'h46;

    // value of the letter digit a
    localparam logic [DIGIT_W-1:0] HEX_ALPHA_BASE = 4'd10;

    // radix select codes, code three reads as decimal
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_HEX = 2'd1;
    localparam logic [1:0] BASE_OCT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_DIGIT  = 2'd1,
        STATUS_OVERFLOW  = 2'd2,
        STATUS_ABOVE_MAX = 2'd3
    } status_t;

    typedef struct packed {
        logic               is_digit;
        logic [DIGIT_W-1:0] value;
    } digit_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        status_t          status;
        logic [CNT_W-1:0] digits_used;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/arp_if.sv
// ----------------------------------------------------------------------------
// arp_if
// valid/ready channels of the parser: byte requests in, results out
// ----------------------------------------------------------------------------
`default_nettype none

interface arp_in_if;
    logic                     valid;
    logic                     ready;
    logic [arp_pkg::CH_W-1:0] ch;
    logic                     start_req;

    modport source (output valid, output ch, output start_req, input ready);
    modport sink (input valid, input ch, input start_req, output ready);
endinterface

interface arp_out_if;
    logic                      valid;
    logic                      ready;
    logic [arp_pkg::VAL_W-1:0] value;
    logic [1:0]                status;
    logic [arp_pkg::CNT_W-1:0] digits_used;

    modport source (output valid, output value, output status, output digits_used,
                    input ready);
    modport sink (input valid, input value, input status, input digits_used,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/arp_digit.sv
// ----------------------------------------------------------------------------
// arp_digit
// classifies one ascii byte as a digit of the selected radix
// ----------------------------------------------------------------------------
`default_nettype none

module arp_digit (
    input  wire logic [arp_pkg::CH_W-1:0] ch,
    input  wire logic [1:0]               number_base,
    output arp_pkg::digit_t               digit
);

    logic                     is_hex;
    logic                     is_oct;
    logic [arp_pkg::CH_W-1:0] num_off;
    logic [arp_pkg::CH_W-1:0] lower_off;
    logic [arp_pkg::CH_W-1:0] upper_off;

    assign is_hex    = (number_base == arp_pkg::BASE_HEX);
    assign is_oct    = (number_base == arp_pkg::BASE_OCT);
    assign num_off   = ch - arp_pkg::CH_ZERO;
    assign lower_off = ch - arp_pkg::CH_LOWER_A;
    assign upper_off = ch - arp_pkg::CH_UPPER_A;

    // numeric digits, eight and nine rejected in octal, letters only in hex
    always_comb
    begin
        digit = '0;
        if ((ch >= arp_pkg::CH_ZERO) && (ch <= arp_pkg::CH_NINE))
        begin
            digit.value    = num_off[arp_pkg::DIGIT_W-1:0];
            digit.is_digit = !(is_oct && num_off[3]);
        end
        else if (is_hex && (ch >= arp_pkg::CH_LOWER_A) && (ch <= arp_pkg::CH_LOWER_F))
        begin
            digit.value    = lower_off[arp_pkg::DIGIT_W-1:0] + arp_pkg::HEX_ALPHA_BASE;
            digit.is_digit = 1'b1;
        end
        else if (is_hex && (ch >= arp_pkg::CH_UPPER_A) && (ch <= arp_pkg::CH_UPPER_F))
        begin
            digit.value    = upper_off[arp_pkg::DIGIT_W-1:0] + arp_pkg::HEX_ALPHA_BASE;
            digit.is_digit = 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/arp_core.sv
// ----------------------------------------------------------------------------
// arp_core
// parse state and the per-byte step: accumulate, range checks, result select
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module arp_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire logic [arp_pkg::CH_W-1:0]  ch,
    input  wire logic                      start_req,
    input  wire logic [1:0]                number_base,
    input  wire logic [arp_pkg::VAL_W-1:0] max_value,
    output logic                           emit,
    output arp_pkg::result_t               result
);

    logic [arp_pkg::VAL_W-1:0]  acc_reg;
    logic [arp_pkg::VAL_W-1:0]  acc_next;
    logic [arp_pkg::CNT_W-1:0]  cnt_reg;
    logic [arp_pkg::CNT_W-1:0]  cnt_next;
    logic                       active_reg;
    logic                       active_next;

    arp_pkg::digit_t            digit;
    logic [arp_pkg::VAL_W-1:0]  acc_base;
    logic [arp_pkg::CNT_W-1:0]  cnt_base;
    logic [arp_pkg::PROD_W-1:0] acc_wide;
    logic [arp_pkg::PROD_W-1:0] prod;
    logic [arp_pkg::PROD_W-1:0] sum;
    logic                       overflow;
    logic                       above_max;

    arp_digit u_digit (
        .ch          (ch),
        .number_base (number_base),
        .digit       (digit)
    );

    // a start byte begins from an empty accumulator
    assign acc_base = start_req ? '0 : acc_reg;
    assign cnt_base = start_req ? '0 : cnt_reg;
    assign acc_wide = arp_pkg::PROD_W'(acc_base);

    // radix multiply as shift and add
    always_comb
    begin
        case (number_base)
            arp_pkg::BASE_HEX: prod = acc_wide << 4;
            arp_pkg::BASE_OCT: prod = acc_wide << 3;
            default:           prod = (acc_wide << 3) + (acc_wide << 1);
        endcase
    end

    assign sum       = prod + arp_pkg::PROD_W'(digit.value);
    assign overflow  = |sum[arp_pkg::PROD_W-1:arp_pkg::VAL_W];
    assign above_max = (sum[arp_pkg::VAL_W-1:0] > max_value);

    // step decision
    always_comb
    begin
        emit               = 1'b0;
        result.value       = '0;
        result.status      = arp_pkg::STATUS_OK;
        result.digits_used = cnt_base;
        acc_next           = acc_reg;
        cnt_next           = cnt_reg;
        active_next        = active_reg;
        if (step && (start_req || active_reg))
        begin
            if (!digit.is_digit)
            begin
                emit        = 1'b1;
                active_next = 1'b0;
                if (start_req)
                begin
                    result.status = arp_pkg::STATUS_NO_DIGIT;
                end
                else
                begin
                    result.value = acc_base;
                end
            end
            else if (overflow)
            begin
                emit          = 1'b1;
                active_next   = 1'b0;
                result.status = arp_pkg::STATUS_OVERFLOW;
            end
            else if (above_max)
            begin
                emit          = 1'b1;
                active_next   = 1'b0;
                result.status = arp_pkg::STATUS_ABOVE_MAX;
            end
            else
            begin
                acc_next    = sum[arp_pkg::VAL_W-1:0];
                cnt_next    = (cnt_base == arp_pkg::CNT_MAX) ? cnt_base : cnt_base + 1'b1;
                active_next = 1'b1;
            end
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
        end
    end

    // checks
    `ASSERT_PROP(a_idle_only_by_step, $fell(active_reg) |-> $past(step), "parse ended without a step")
    `ASSERT_NEVER(a_emit_keeps_active, emit && active_next, "result given while parse continues")
    `ASSERT_PROP(a_digit_advances, step && active_next |=> active_reg && (cnt_reg != '0), "digit not counted")

endmodule

`default_nettype wire

// File: rtl/ascii_radix_number_parser.sv
// ----------------------------------------------------------------------------
// ascii_radix_number_parser
// streaming parser of unsigned decimal, hex or octal numbers from ascii bytes
// ----------------------------------------------------------------------------
// byte_in carries one ascii byte per request with start_req marking the first
// byte of a number; result_out carries value, status and digits_used once a
// number ends on a non-digit byte or on an error.
// cfg_wr_en writes register cfg_addr (0 number_base, 1 max_value) from cfg_wdata;
// the user must use it only while no parse is in flight; the block does not enforce it.
// throughput: one byte per cycle while result_out is not stalled; the accumulate step is
// a shift-add and one 63-bit compare between the input register and the result register.
// a byte accepted into the input register is evaluated there and its result is
// captured in the result register, from which it is offered.
// a result register parts the two sides: while a result waits, one more byte
// is taken into the input register, then byte_in.ready drops until the result
// is taken.
// reset clears the parse state and both registers to decimal and the largest
// value; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ascii_radix_number_parser (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    arp_in_if.sink                                   byte_in,
    arp_out_if.source                                result_out,
    input  wire logic                                cfg_wr_en,
    input  wire logic [arp_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  wire logic [arp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    logic [1:0]                number_base_reg;
    logic [arp_pkg::VAL_W-1:0] max_value_reg;

    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic [arp_pkg::CH_W-1:0]  ch_reg;
    logic                      start_reg;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    arp_pkg::result_t          result_reg;

    logic                      accept;
    logic                      advance;
    logic                      step;
    logic                      emit;
    arp_pkg::result_t          result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= arp_pkg::BASE_DEC;
            max_value_reg   <= arp_pkg::VAL_MAX;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                arp_pkg::REG_NUMBER_BASE: number_base_reg <= cfg_wdata[1:0];
                arp_pkg::REG_MAX_VALUE:   max_value_reg   <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    // handshake and stage advance
    assign advance       = !out_valid_reg || result_out.ready;
    assign byte_in.ready = !in_valid_reg || advance;
    assign accept        = byte_in.valid && byte_in.ready;
    assign step          = in_valid_reg && advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    assign out_valid_next = advance ? emit : out_valid_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg    <= byte_in.ch;
            start_reg <= byte_in.start_req;
        end
    end

    arp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .ch          (ch_reg),
        .start_req   (start_reg),
        .number_base (number_base_reg),
        .max_value   (max_value_reg),
        .emit        (emit),
        .result      (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            result_reg <= result;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.value       = result_reg.value;
    assign result_out.status      = result_reg.status;
    assign result_out.digits_used = result_reg.digits_used;

    // checks
    `ASSERT_NEVER(a_error_value_zero, out_valid_reg && (result_reg.status != arp_pkg::STATUS_OK) && (result_reg.value != '0), "error result with nonzero value")
    `ASSERT_NEVER(a_no_digit_count, out_valid_reg && (result_reg.status == arp_pkg::STATUS_NO_DIGIT) && (result_reg.digits_used != '0), "no-digit result with a count")
    `ASSERT_PROP(a_stall_holds_input, in_valid_reg && !advance |=> in_valid_reg && $stable(ch_reg), "pending byte lost under stall")

endmodule

`default_nettype wire

// File: sim/tb_ascii_radix_number_parser.sv
// ----------------------------------------------------------------------------
// tb_ascii_radix_number_parser
// self-checking bench of the streaming decimal, hex and octal byte parser
// ----------------------------------------------------------------------------
// byte requests go in on a valid/ready channel and every accepted byte is fed
// to a local model of the parser, which queues the number it completes. each
// result taken from the block is checked field by field against the oldest
// queued number. directed cases cover the error codes, restarts, ignored
// bytes, the radix boundaries and count saturation; a random stream of
// well-formed numbers, boundary values and noise then runs under several
// register settings and three idling patterns of both channel sides.
// ----------------------------------------------------------------------------

module tb_ascii_radix_number_parser;

    import arp_pkg::*;

    localparam int SETTLE_CYCLES     = 4;
    localparam int STALL_LIMIT       = 2000;
    localparam int BYTES_PER_SETTING = 20;
    localparam int REPORT_LIMIT      = 10;
    localparam int SATURATION_ZEROS  = 1030;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    arp_in_if  req_if ();
    arp_out_if res_if ();

    ascii_radix_number_parser uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (req_if),
        .result_out (res_if),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    // local copy of the registers and of the parse state
    logic [1:0]       radix_sel     = BASE_DEC;
    logic [VAL_W-1:0] value_ceiling = VAL_MAX;
    logic [VAL_W-1:0] run_value     = '0;
    logic [CNT_W-1:0] run_digits    = '0;
    logic             in_number     = 1'b0;

    // numbers completed by the model, oldest first
    result_t parsed_numbers[$];

    int unsigned fail_count   = 0;
    int unsigned useful_bytes = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] radix_of(input logic [1:0] sel);
        case (sel)
            BASE_HEX: return 64'd16;
            BASE_OCT: return 64'd8;
            default:  return 64'd10;
        endcase
    endfunction

    // digit value of a byte in the given radix, returns 0 for a non-digit
    function automatic logic digit_value(input logic [CH_W-1:0] c, input logic [63:0] radix,
                                         output logic [DIGIT_W-1:0] dv);
        logic [CH_W-1:0] offset;
        dv = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            offset = c - CH_ZERO;
            dv = offset[DIGIT_W-1:0];
            return !(radix == 64'd8 && dv > 4'd7);
        end
        if (radix == 64'd16)
        begin
            if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            begin
                offset = c - CH_LOWER_A;
                dv = offset[DIGIT_W-1:0] + HEX_ALPHA_BASE;
                return 1'b1;
            end
            if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            begin
                offset = c - CH_UPPER_A;
                dv = offset[DIGIT_W-1:0] + HEX_ALPHA_BASE;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // advance the parse by one byte, returns 1 when a number is completed
    function automatic logic parse_byte(input logic [CH_W-1:0] c, input logic first,
                                        output result_t res);
        logic [63:0]        radix;
        logic [63:0]        grown;
        logic [DIGIT_W-1:0] dv;
        logic               is_dig;
        radix  = radix_of(radix_sel);
        is_dig = digit_value(c, radix, dv);
        res    = '0;
        if (first)
        begin
            run_value  = '0;
            run_digits = '0;
            in_number  = 1'b1;
            if (!is_dig)
            begin
                res.status = STATUS_NO_DIGIT;
                in_number  = 1'b0;
                return 1'b1;
            end
        end
        else if (!in_number)
            return 1'b0;
        // first non-digit closes the number
        if (!is_dig)
        begin
            res.value       = run_value;
            res.status      = STATUS_OK;
            res.digits_used = run_digits;
            in_number       = 1'b0;
            return 1'b1;
        end
        // wide compare against the 63-bit limit before growing
        if ({1'b0, run_value} > ({1'b0, VAL_MAX} - {60'd0, dv}) / radix)
        begin
            res.status      = STATUS_OVERFLOW;
            res.digits_used = run_digits;
            in_number       = 1'b0;
            return 1'b1;
        end
        grown     = {1'b0, run_value} * radix + {60'd0, dv};
        run_value = grown[VAL_W-1:0];
        if (run_value > value_ceiling)
        begin
            res.status      = STATUS_ABOVE_MAX;
            res.digits_used = run_digits;
            in_number       = 1'b0;
            return 1'b1;
        end
        if (run_digits != CNT_MAX)
            run_digits = run_digits + 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [CH_W-1:0] digit_char(input int unsigned d, input logic upper);
        if (d < 10)
            return CH_ZERO + CH_W'(d);
        return (upper ? CH_UPPER_A : CH_LOWER_A) + CH_W'(d - 10);
    endfunction

    function automatic logic [CH_W-1:0] random_non_digit();
        logic [CH_W-1:0]    c;
        logic [DIGIT_W-1:0] dv;
        do
            c = CH_W'($urandom_range(255));
        while (digit_value(c, radix_of(radix_sel), dv));
        return c;
    endfunction

    // one byte request, with random idle cycles ahead of it
    task automatic send_byte(input logic [CH_W-1:0] c, input logic first);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.ch        <= c;
        req_if.start_req <= first;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    // hold off requests until every queued number has come back
    task automatic drain_results();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (parsed_numbers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [1:0] base_sel, input logic [VAL_W-1:0] ceiling);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_NUMBER_BASE;
        cfg_wdata <= {{(CFG_DATA_W-2){1'b0}}, base_sel};
        @(posedge clk);
        cfg_addr  <= REG_MAX_VALUE;
        cfg_wdata <= ceiling;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        radix_sel     = base_sel;
        value_ceiling = ceiling;
    endtask

    // close any open number, let the block go idle, then write both registers
    task automatic reconfigure(input logic [1:0] base_sel, input logic [VAL_W-1:0] ceiling);
        send_byte(8'h00, 1'b0);
        drain_results();
        write_config(base_sel, ceiling);
    endtask

    // a value written out in the current radix, optionally padded or extended
    task automatic send_value_text(input logic [63:0] v, input int lead_zeros,
                                   input logic extra_digit);
        logic [CH_W-1:0] text[$];
        logic [63:0]     radix;
        logic [63:0]     rem;
        radix = radix_of(radix_sel);
        rem   = v;
        do
        begin
            text.push_front(digit_char(32'(rem % radix), 1'($urandom_range(1))));
            rem = rem / radix;
        end
        while (rem != 0);
        repeat (lead_zeros) text.push_front(CH_ZERO);
        if (extra_digit)
            text.push_back(digit_char($urandom_range(32'(radix - 64'd1)),
                                      1'($urandom_range(1))));
        foreach (text[i])
            send_byte(text[i], i == 0);
    endtask

    // reset defaults, no-digit starts, restarts and ignored bytes
    task automatic test_decimal_basics();
        send_byte("0", 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte("5", 1'b0);
        send_byte("1", 1'b1);
        send_byte("2", 1'b0);
        send_byte("3", 1'b1);
        send_byte("4", 1'b0);
        send_byte("x", 1'b0);
        send_byte("0", 1'b1);
        send_byte("0", 1'b0);
        send_byte("7", 1'b0);
        send_byte("/", 1'b0);
        send_byte(":", 1'b1);
    endtask

    // letter digits of both cases and the too-big error
    task automatic test_hex_ceiling();
        reconfigure(BASE_HEX, VAL_W'(255));
        send_byte("f", 1'b1);
        send_byte("F", 1'b0);
        send_byte(" ", 1'b0);
        send_byte("1", 1'b1);
        send_byte("0", 1'b0);
        send_byte("0", 1'b0);
        send_byte("5", 1'b0);
        send_byte("g", 1'b1);
    endtask

    // selector three reads as decimal, octal rejects eight
    task automatic test_base_three_and_octal();
        reconfigure(2'd3, '0);
        send_byte("0", 1'b1);
        send_byte("a", 1'b0);
        send_byte("1", 1'b1);
        reconfigure(BASE_OCT, VAL_MAX);
        send_byte("8", 1'b1);
        send_byte("7", 1'b1);
        send_byte("8", 1'b0);
    endtask

    // largest value accepted, one past it overflows, ceiling and one past it
    task automatic test_overflow_boundary();
        logic [1:0]  sel;
        logic [63:0] wide;
        for (int b = 0; b < 3; b++)
        begin
            sel = 2'(b);
            reconfigure(sel, VAL_MAX);
            send_value_text({1'b0, VAL_MAX}, 1, 1'b0);
            send_byte(8'h00, 1'b0);
            send_value_text(64'h8000_0000_0000_0000, 0, 1'b0);
            send_byte(random_non_digit(), 1'b0);
            wide = {$urandom(), $urandom()};
            wide[63] = 1'b0;
            reconfigure(sel, wide[VAL_W-1:0]);
            send_value_text(wide, 0, 1'b0);
            send_byte(random_non_digit(), 1'b0);
            send_value_text(wide + 64'd1, 0, 1'b0);
            send_byte(random_non_digit(), 1'b0);
        end
    endtask

    // digit count stops at its top while the value keeps accumulating
    task automatic test_digit_saturation();
        reconfigure(BASE_DEC, VAL_MAX);
        send_byte("0", 1'b1);
        repeat (SATURATION_ZEROS) send_byte("0", 1'b0);
        send_byte("4", 1'b0);
        send_byte("2", 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // random numbers, boundary values and noise under three register settings
    task automatic test_random_stream(input int s_pct, input int r_pct, input int first_setting);
        int unsigned target;
        int unsigned len;
        int unsigned d;
        int          k;
        logic [63:0] radix;
        logic [63:0] wide;
        logic [63:0] v;
        logic [VAL_W-1:0] ceiling;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int s = 0; s < 3; s++)
        begin
            k = first_setting + s;
            wide = {$urandom(), $urandom()};
            wide[63] = 1'b0;
            if (k == 0)
                ceiling = VAL_MAX;
            else if (k == 1)
                ceiling = '0;
            else
                case ($urandom_range(3))
                    0: ceiling = VAL_MAX;
                    1: ceiling = VAL_W'($urandom_range(1, 100000));
                    2: ceiling = wide[VAL_W-1:0];
                    default: ceiling = VAL_MAX >> $urandom_range(1, 62);
                endcase
            reconfigure(2'(k), ceiling);
            radix  = radix_of(radix_sel);
            target = useful_bytes + BYTES_PER_SETTING;
            while (useful_bytes < target)
            begin
                case ($urandom_range(99)) inside
                    // well-formed number with random digits
                    [0:54]:
                    begin
                        len = ($urandom_range(9) == 0) ? $urandom_range(10, 24)
                                                       : $urandom_range(1, 6);
                        for (int i = 0; i < len; i++)
                        begin
                            d = $urandom_range(32'(radix - 64'd1));
                            if (i < 2 && $urandom_range(3) == 0)
                                d = 0;
                            send_byte(digit_char(d, 1'($urandom_range(1))), i == 0);
                        end
                        case ($urandom_range(9))
                            0: ;
                            1: send_byte(8'h00, 1'b0);
                            default: send_byte(random_non_digit(), 1'b0);
                        endcase
                    end
                    // value next to the ceiling or the 63-bit limit
                    [55:74]:
                    begin
                        wide = {$urandom(), $urandom()};
                        wide[63] = 1'b0;
                        case ($urandom_range(3))
                            0: v = {1'b0, value_ceiling};
                            1: v = {1'b0, VAL_MAX};
                            2: v = wide;
                            default: v = 64'($urandom_range(4096));
                        endcase
                        case ($urandom_range(2))
                            0: if (v != 0) v = v - 64'd1;
                            1: ;
                            default: v = v + 64'd1;
                        endcase
                        send_value_text(v, ($urandom_range(5) == 0) ? $urandom_range(1, 3) : 0,
                                        $urandom_range(7) == 0);
                        send_byte(random_non_digit(), 1'b0);
                    end
                    // start on an arbitrary byte
                    [75:84]:
                        send_byte(CH_W'($urandom_range(255)), 1'b1);
                    // noise without start
                    default:
                        repeat ($urandom_range(1, 4))
                            send_byte(CH_W'($urandom_range(255)), 1'b0);
                endcase
                if ($urandom_range(49) == 0)
                    drain_results();
            end
        end
    endtask

    // result side ready with random stalls
    initial
    begin : result_sink
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // check each result, then fold each accepted request into the model
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        result_t got;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (parsed_numbers.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result: value %0d status %0d digits %0d",
                             res_if.value, res_if.status, res_if.digits_used);
            end
            else
            begin
                want = parsed_numbers.pop_front();
                if (res_if.value != want.value || res_if.status != want.status
                    || res_if.digits_used != want.digits_used)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("result mismatch: value %0d/%0d status %0d/%0d digits %0d/%0d",
                                 want.value, res_if.value, want.status, res_if.status,
                                 want.digits_used, res_if.digits_used);
                end
            end
        end
        if (rst_n && req_if.valid && req_if.ready)
        begin
            if (req_if.start_req || in_number)
                useful_bytes++;
            if (parse_byte(req_if.ch, req_if.start_req, got))
                parsed_numbers.push_back(got);
        end
    end

    // end the run when nothing moves on either channel for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // test sequence
    initial
    begin
        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_addr         <= REG_NUMBER_BASE;
        cfg_wdata        <= '0;
        req_if.valid     <= 1'b0;
        req_if.ch        <= '0;
        req_if.start_req <= 1'b0;
        send_idle_pct    = 32;
        recv_idle_pct    = 83;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_decimal_basics();
        test_hex_ceiling();
        test_base_three_and_octal();
        test_overflow_boundary();
        test_digit_saturation();
        test_random_stream(32, 83, 0);
        test_random_stream(83, 32, 3);
        test_random_stream(0, 0, 6);

        send_byte(8'h00, 1'b0);
        drain_results();
        fail_count += parsed_numbers.size();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/arp_pkg.sv
rtl/arp_if.sv
rtl/arp_digit.sv
rtl/arp_core.sv
rtl/ascii_radix_number_parser.sv
sim/tb_ascii_radix_number_parser.sv
